FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the sphere frustum cull block.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/sfc_pkg.sv
// Package for the sphere frustum cull block: register layouts, codes and widths.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sfc_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOUND  = 3'd0,
		REG_LEFT   = 3'd1,
		REG_RIGHT  = 3'd2,
		REG_TOP    = 3'd3,
		REG_BOTTOM = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		CAUSE_NONE   = 3'd0,
		CAUSE_BOUND  = 3'd1,
		CAUSE_LEFT   = 3'd2,
		CAUSE_RIGHT  = 3'd3,
		CAUSE_TOP    = 3'd4,
		CAUSE_BOTTOM = 3'd5
	} cause_t;

	// Which side of a plane rejects: above the radius or below its negative.
	typedef enum logic {
		SIDE_ABOVE = 1'b0,
		SIDE_BELOW = 1'b1
	} side_t;

	typedef struct packed {
		logic signed [15:0] rad;
		logic signed [15:0] cz;
		logic signed [15:0] cy;
		logic signed [15:0] cx;
	} bound_t;

	typedef struct packed {
		logic signed [15:0] d;
		logic signed [15:0] nz;
		logic signed [15:0] ny;
		logic signed [15:0] nx;
	} plane_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic        [14:0] r;
	} sphere_t;

endpackage

FILE: sv/sphere_frustum_cull.sv
// Top level of the sphere frustum cull block: configuration registers, input register,
// four plane tests, bounding sphere test and result register. Depends on sfc_pkg,
// sfc_bound, sfc_plane and assert_macros.svh.
// done is registered from valid_s2, which follows valid_s1, set on the edge that transfers an item.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// Reset clears the configuration registers to zero and drops all valid flags; nothing is in flight after it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sphere_frustum_cull (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [15:0]            center_x,
	input  logic signed [15:0]            center_y,
	input  logic signed [15:0]            center_z,
	input  logic        [14:0]            sphere_radius,
	output logic                          done,
	output logic                          visible,
	output logic        [2:0]             reject_cause,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);
	import sfc_pkg::*;

	bound_t  bound_q;
	plane_t  left_q, right_q, top_q, bottom_q;
	sphere_t sph_s1;
	logic    valid_s1, valid_s2;
	logic    rej_bound, rej_left, rej_right, rej_top, rej_bottom;
	cause_t  cause;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q  <= '0;
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BOUND:  bound_q  <= bound_t'(cfg_data);
				REG_LEFT:   left_q   <= plane_t'(cfg_data);
				REG_RIGHT:  right_q  <= plane_t'(cfg_data);
				REG_TOP:    top_q    <= plane_t'(cfg_data);
				REG_BOTTOM: bottom_q <= plane_t'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			sph_s1 <= '{x: center_x, y: center_y, z: center_z, r: sphere_radius};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

	sfc_bound u_bound (.clk(clk), .sph(sph_s1), .bnd(bound_q), .reject(rej_bound));
	sfc_plane u_left (.clk(clk), .side(SIDE_ABOVE), .sph(sph_s1), .pln(left_q),
		.reject(rej_left));
	sfc_plane u_right (.clk(clk), .side(SIDE_BELOW), .sph(sph_s1), .pln(right_q),
		.reject(rej_right));
	sfc_plane u_top (.clk(clk), .side(SIDE_BELOW), .sph(sph_s1), .pln(top_q),
		.reject(rej_top));
	sfc_plane u_bottom (.clk(clk), .side(SIDE_ABOVE), .sph(sph_s1), .pln(bottom_q),
		.reject(rej_bottom));

	always_comb begin
		if (rej_bound) begin
			cause = CAUSE_BOUND;
		end else if (rej_left) begin
			cause = CAUSE_LEFT;
		end else if (rej_right) begin
			cause = CAUSE_RIGHT;
		end else if (rej_top) begin
			cause = CAUSE_TOP;
		end else if (rej_bottom) begin
			cause = CAUSE_BOTTOM;
		end else begin
			cause = CAUSE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			visible      <= (cause == CAUSE_NONE);
			reject_cause <= cause;
		end
	end

	`ASSERT_NXT(a_s1_to_s2, valid_s1, valid_s2)
	`ASSERT_NXT(a_s2_to_done, valid_s2, done)
	`ASSERT_IMP(a_visible_cause, done, visible == (reject_cause == CAUSE_NONE))
	`ASSERT_IMP(a_cause_range, done, reject_cause <= CAUSE_BOTTOM)

endmodule

FILE: sv/sfc_bound.sv
// Bounding sphere test: squares registered, then the sum is compared with the radius sum squared.
// Depends on sfc_pkg.
`timescale 1ns / 1ps

module sfc_bound (
	input  logic            clk,
	input  sfc_pkg::sphere_t sph,
	input  sfc_pkg::bound_t  bnd,
	output logic            reject
);
	import sfc_pkg::*;

	logic signed [16:0] dx, dy, dz, rsum;
	logic signed [33:0] sqx, sqy, sqz, sqr;
	logic        [31:0] sqx_s2, sqy_s2, sqz_s2, sqr_s2;
	logic               rneg_s2;
	logic        [33:0] d2;

	always_comb begin
		dx   = {sph.x[15], sph.x} - {bnd.cx[15], bnd.cx};
		dy   = {sph.y[15], sph.y} - {bnd.cy[15], bnd.cy};
		dz   = {sph.z[15], sph.z} - {bnd.cz[15], bnd.cz};
		rsum = {bnd.rad[15], bnd.rad} + $signed({2'b00, sph.r});
		sqx  = dx * dx;
		sqy  = dy * dy;
		sqz  = dz * dz;
		sqr  = rsum * rsum;
	end

	always_ff @(posedge clk) begin
		sqx_s2  <= sqx[31:0];
		sqy_s2  <= sqy[31:0];
		sqz_s2  <= sqz[31:0];
		sqr_s2  <= sqr[31:0];
		rneg_s2 <= rsum[16];
	end

	assign d2     = {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
	assign reject = rneg_s2 || (d2 > {2'b00, sqr_s2});

endmodule

FILE: sv/sfc_plane.sv
// One side plane test: products registered, then the signed distance is compared with the radius.
// Depends on sfc_pkg.
`timescale 1ns / 1ps

module sfc_plane (
	input  logic            clk,
	input  sfc_pkg::side_t   side,
	input  sfc_pkg::sphere_t sph,
	input  sfc_pkg::plane_t  pln,
	output logic            reject
);
	import sfc_pkg::*;

	logic signed [31:0] px, py, pz;
	logic signed [31:0] px_s2, py_s2, pz_s2;
	logic signed [15:0] d_s2;
	logic        [14:0] r_s2;
	logic signed [33:0] distance, rs, rs_neg;

	always_comb begin
		px = pln.nx * sph.x;
		py = pln.ny * sph.y;
		pz = pln.nz * sph.z;
	end

	always_ff @(posedge clk) begin
		px_s2 <= px;
		py_s2 <= py;
		pz_s2 <= pz;
		d_s2  <= pln.d;
		r_s2  <= sph.r;
	end

	always_comb begin
		rs       = $signed({5'b00000, r_s2, 14'b0});
		rs_neg   = -rs;
		distance = {{2{px_s2[31]}}, px_s2} + {{2{py_s2[31]}}, py_s2}
		         + {{2{pz_s2[31]}}, pz_s2} + {{4{d_s2[15]}}, d_s2, 14'b0};
		if (side == SIDE_ABOVE) begin
			reject = distance > rs;
		end else begin
			reject = distance < rs_neg;
		end
	end

endmodule

FILE: verif/tb.sv
// Self-checking testbench for sphere_frustum_cull: predicts the cull verdict of every sphere
// and compares it with each strobed result. Depends on sfc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;

	import sfc_pkg::*;

	localparam int     NUM_REGS      = 5;
	localparam longint NORMAL_ONE    = 16384;
	localparam int     DRAIN_CYCLES  = 8;
	localparam int     RANDOM_PHASES = 24;
	localparam int     PHASE_ITEMS   = 60;
	localparam int     TIMEOUT_NS    = 3_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [15:0]   center_x;
	logic signed [15:0]   center_y;
	logic signed [15:0]   center_z;
	logic        [14:0]   sphere_radius;
	logic                 done;
	logic                 visible;
	logic        [2:0]    reject_cause;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;

	logic [63:0] cfg_shadow [NUM_REGS];
	cause_t      expected_causes [$];
	int          cause_hits [6];
	int          items_sent;
	int          results_checked;
	int          mismatches;
	int          settings_used;

	sphere_frustum_cull DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.center_x     (center_x),
		.center_y     (center_y),
		.center_z     (center_z),
		.sphere_radius(sphere_radius),
		.done         (done),
		.visible      (visible),
		.reject_cause (reject_cause),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results still outstanding.", expected_causes.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [63:0] make_word(logic [15:0] f0, logic [15:0] f1,
		logic [15:0] f2, logic [15:0] f3);
		return {f3, f2, f1, f0};
	endfunction

	function automatic sphere_t ball(int x, int y, int z, int r);
		return {x[15:0], y[15:0], z[15:0], r[14:0]};
	endfunction

	function automatic longint plane_distance(plane_t p, sphere_t s);
		longint nx, ny, nz, d, x, y, z;
		nx = p.nx;
		ny = p.ny;
		nz = p.nz;
		d  = p.d;
		x  = s.x;
		y  = s.y;
		z  = s.z;
		return nx * x + ny * y + nz * z + d * NORMAL_ONE;
	endfunction

	function automatic cause_t cull_cause(sphere_t s);
		bound_t b;
		longint dx, dy, dz, rad, rsum, d2, rscaled;
		b = cfg_shadow[REG_BOUND];
		dx = s.x;
		dx = dx - b.cx;
		dy = s.y;
		dy = dy - b.cy;
		dz = s.z;
		dz = dz - b.cz;
		rad = s.r;
		rsum = b.rad;
		rsum = rsum + rad;
		rscaled = rad * NORMAL_ONE;
		d2 = dx * dx + dy * dy + dz * dz;
		if (rsum < 0 || d2 > rsum * rsum)
			return CAUSE_BOUND;
		if (plane_distance(cfg_shadow[REG_LEFT], s) > rscaled)
			return CAUSE_LEFT;
		if (plane_distance(cfg_shadow[REG_RIGHT], s) < -rscaled)
			return CAUSE_RIGHT;
		if (plane_distance(cfg_shadow[REG_TOP], s) < -rscaled)
			return CAUSE_TOP;
		if (plane_distance(cfg_shadow[REG_BOTTOM], s) > rscaled)
			return CAUSE_BOTTOM;
		return CAUSE_NONE;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch on result %0d: %s, expected %0d, got %0d",
				results_checked, what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		cause_t want;
		if (arst_n && done) begin
			if (expected_causes.size() == 0) begin
				report_mismatch("result with no item outstanding", -1, reject_cause);
			end else begin
				want = expected_causes.pop_front();
				if (visible !== (want == CAUSE_NONE))
					report_mismatch("visible", want == CAUSE_NONE, visible);
				if (reject_cause !== want)
					report_mismatch("reject_cause", want, reject_cause);
			end
			results_checked++;
		end
	end

	task automatic send_item(sphere_t s);
		cause_t c;
		c = cull_cause(s);
		start         <= 1'b1;
		center_x      <= s.x;
		center_y      <= s.y;
		center_z      <= s.z;
		sphere_radius <= s.r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_causes.push_back(c);
		cause_hits[c]++;
		items_sent++;
	endtask

	task automatic pause(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_causes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx < NUM_REGS)
			cfg_shadow[idx] = value;
	endtask

	task automatic write_all(logic [63:0] bound, logic [63:0] left, logic [63:0] right,
		logic [63:0] top, logic [63:0] bottom);
		settle();
		write_reg(REG_BOUND, bound);
		write_reg(REG_LEFT, left);
		write_reg(REG_RIGHT, right);
		write_reg(REG_TOP, top);
		write_reg(REG_BOTTOM, bottom);
		settings_used++;
	endtask

	task automatic test_reset_state();
		send_item(ball(0, 0, 0, 0));
		send_item(ball(0, 0, 0, 32767));
		send_item(ball(1, 0, 0, 0));
	endtask

	task automatic test_bound_sphere();
		write_all(make_word(0, 0, 0, 16'h7FFF), 0, 0, 0, 0);
		send_item(ball(32767, 32767, 32767, 0));
		send_item(ball(-32768, -32768, -32768, 0));
		send_item(ball(32767, 0, 0, 0));
		send_item(ball(32767, 1, 0, 0));
		send_item(ball(32767, 32767, 32767, 32767));
		send_item(ball(-32768, -32768, -32768, 32767));
		// A radius sum below zero rejects even a sphere at the exact center.
		write_all(make_word(0, 0, 0, 16'hFFFB), 0, 0, 0, 0);
		send_item(ball(0, 0, 0, 4));
		send_item(ball(0, 0, 0, 5));
		write_all(make_word(0, 0, 0, 16'h8000), 0, 0, 0, 0);
		send_item(ball(0, 0, 0, 32767));
	endtask

	task automatic test_planes();
		write_all(make_word(0, 0, 0, 16'h7FFF), make_word(16384, 0, 0, 0),
			make_word(16384, 0, 0, 0), make_word(0, 16384, 0, 0),
			make_word(0, 16384, 0, 0));
		send_item(ball(0, 0, 0, 0));
		send_item(ball(17, 0, 0, 16));
		send_item(ball(16, 0, 0, 16));
		send_item(ball(-17, 0, 0, 16));
		send_item(ball(0, -17, 0, 16));
		send_item(ball(0, 17, 0, 16));
		send_item(ball(100, 100, 0, 0));
		// Normals well outside unit length, with offsets at the ends of their range.
		write_all(make_word(0, 0, 0, 16'h7FFF),
			make_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000),
			make_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF),
			make_word(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF),
			make_word(16'h8000, 16'h8000, 16'h7FFF, 16'h8000));
		send_item(ball(-32768, 32767, -32768, 32767));
		send_item(ball(32767, -32768, 32767, 0));
		send_item(ball(5, -3, 2, 100));
	endtask

	task automatic test_unused_index();
		write_all(0, 0, 0, 0, 0);
		for (int i = NUM_REGS; i < 2 ** CFG_IDX_W; i++)
			write_reg(i[CFG_IDX_W-1:0], '1);
		send_item(ball(0, 0, 0, 0));
		send_item(ball(0, 0, 0, 32767));
	endtask

	function automatic logic [15:0] near(logic signed [15:0] base, int spread);
		int v;
		v = base;
		v = v + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic logic [63:0] random_plane(bit rejects_above);
		int nx, ny, nz, d;
		nx = int'($urandom_range(0, 32768)) - 16384;
		ny = int'($urandom_range(0, 32768)) - 16384;
		nz = int'($urandom_range(0, 32768)) - 16384;
		if (rejects_above)
			d = int'($urandom_range(0, 36768)) - 32768;
		else
			d = int'($urandom_range(0, 36767)) - 4000;
		return make_word(nx[15:0], ny[15:0], nz[15:0], d[15:0]);
	endfunction

	function automatic logic [63:0] random_bound();
		int cx, cy, cz, rad;
		cx = int'($urandom_range(0, 2048)) - 1024;
		cy = int'($urandom_range(0, 2048)) - 1024;
		cz = int'($urandom_range(0, 2048)) - 1024;
		if ($urandom_range(0, 9) == 0)
			rad = -int'($urandom_range(1, 32768));
		else
			rad = $urandom_range(1000, 32767);
		return make_word(cx[15:0], cy[15:0], cz[15:0], rad[15:0]);
	endfunction

	function automatic sphere_t random_sphere();
		sphere_t s;
		bound_t b;
		logic [63:0] raw;
		b = cfg_shadow[REG_BOUND];
		raw = {$urandom(), $urandom()};
		if ($urandom_range(0, 9) < 7) begin
			s.x = near(b.cx, 4096);
			s.y = near(b.cy, 4096);
			s.z = near(b.cz, 4096);
			s.r = ($urandom_range(0, 7) == 0) ? raw[14:0] : 15'($urandom_range(0, 2047));
		end else begin
			s = raw[62:0];
		end
		return s;
	endfunction

	task automatic test_random_scenes();
		int burst_left;
		logic [63:0] w;
		burst_left = 0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: write_all('1, '1, '1, '1, '1);
				1: write_all('0, '0, '0, '0, '0);
				2: begin
					w = {4{16'h7FFF}};
					write_all(w, w, w, w, w);
				end
				3: begin
					w = {4{16'h8000}};
					write_all(w, w, w, w, w);
				end
				default: begin
					if (phase % 4 == 0)
						write_all({$urandom(), $urandom()}, {$urandom(), $urandom()},
							{$urandom(), $urandom()}, {$urandom(), $urandom()},
							{$urandom(), $urandom()});
					else
						write_all(random_bound(), random_plane(1'b1), random_plane(1'b0),
							random_plane(1'b0), random_plane(1'b1));
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					pause($urandom_range(1, 5));
					burst_left = $urandom_range(1, 40);
				end
				send_item(random_sphere());
				burst_left--;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		center_x      = '0;
		center_y      = '0;
		center_z      = '0;
		sphere_radius = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		items_sent      = 0;
		results_checked = 0;
		mismatches      = 0;
		settings_used   = 1;
		foreach (cfg_shadow[i])
			cfg_shadow[i] = '0;
		foreach (cause_hits[i])
			cause_hits[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_bound_sphere();
		test_planes();
		test_unused_index();
		test_random_scenes();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Culled %0d spheres under %0d register settings, %0d results checked.",
			items_sent, settings_used, results_checked);
		$display("Verdicts: visible %0d, bound %0d, left %0d, right %0d, top %0d, bottom %0d.",
			cause_hits[CAUSE_NONE], cause_hits[CAUSE_BOUND], cause_hits[CAUSE_LEFT],
			cause_hits[CAUSE_RIGHT], cause_hits[CAUSE_TOP], cause_hits[CAUSE_BOTTOM]);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
